### hdl/mfam_pkg.sv
// Package for the mixed-number fraction unit: payload structs, widths,
// micro-op codes and the microcode ROM contents.
// No dependencies.
package mfam_pkg;

    // Operand and result widths
    localparam int OPERAND_BITS = 12;
    localparam int FRAC_BITS    = OPERAND_BITS - 1;
    localparam int FUNC_BITS    = 2;
    localparam int NUM_BITS     = 45;
    localparam int DEN_BITS     = 22;
    localparam int MAG_BITS     = NUM_BITS - 1;
    localparam int T_BITS       = 2 * OPERAND_BITS;
    localparam int MUL_BITS     = T_BITS + 1;
    localparam int K_BITS       = 5;
    localparam int CNT_BITS     = 6;
    localparam int UPC_BITS     = 5;

    // Operation codes
    localparam logic [FUNC_BITS-1:0] FN_CONVERT  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FN_ADD      = 2'd1;
    localparam logic [FUNC_BITS-1:0] FN_MULTIPLY = 2'd2;

    typedef struct packed {
        logic [FUNC_BITS-1:0]           func;
        logic signed [OPERAND_BITS-1:0] first_whole;
        logic [FRAC_BITS-1:0]           first_numerator;
        logic [FRAC_BITS-1:0]           first_denominator;
        logic signed [OPERAND_BITS-1:0] second_whole;
        logic [FRAC_BITS-1:0]           second_numerator;
        logic [FRAC_BITS-1:0]           second_denominator;
    } t_in_item;

    typedef struct packed {
        logic signed [NUM_BITS-1:0] result_numerator;
        logic [DEN_BITS-1:0]        result_denominator;
        logic                       zero_denominator_error;
    } t_out_item;

    // Datapath micro-ops
    typedef enum logic [4:0] {
        OP_NOP,
        OP_WAIT_IN,
        OP_MUL_W1D1,
        OP_SET_T1,
        OP_MUL_W2D2,
        OP_SET_T2,
        OP_MUL_T1D2,
        OP_ACC_LOAD,
        OP_MUL_D1T2,
        OP_ACC_ADD,
        OP_MUL_T1T2,
        OP_MUL_D1D2,
        OP_LOAD_DEN,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_GCD_DONE,
        OP_DIV_LOAD_NUM,
        OP_DIV_STEP,
        OP_DIV_STORE_NUM,
        OP_DIV_LOAD_DEN,
        OP_DIV_STORE_DEN,
        OP_EMIT,
        OP_SET_ONE,
        OP_SET_ERR,
        OP_SET_ZERO,
        OP_CONV
    } t_op;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_FUNC_BAD,
        C_DEN_ERR,
        C_FUNC_CONV,
        C_FUNC_MUL,
        C_NUM_ZERO,
        C_GCD_RUN,
        C_DIV_MORE
    } t_cond;

    typedef struct packed {
        t_op                 op;
        t_cond               cond;
        logic [UPC_BITS-1:0] target;
    } t_uinst;

    // Status from datapath to sequencer
    typedef struct packed {
        logic func_bad;
        logic den_err;
        logic func_conv;
        logic func_mul;
        logic num_zero;
        logic gcd_run;
        logic div_more;
    } t_dp_flags;

    // Program labels
    localparam logic [UPC_BITS-1:0] L_IDLE    = 5'd0;
    localparam logic [UPC_BITS-1:0] L_MUL     = 5'd10;
    localparam logic [UPC_BITS-1:0] L_DEN     = 5'd12;
    localparam logic [UPC_BITS-1:0] L_GCD     = 5'd15;
    localparam logic [UPC_BITS-1:0] L_DIV_NUM = 5'd18;
    localparam logic [UPC_BITS-1:0] L_DIV_DEN = 5'd21;
    localparam logic [UPC_BITS-1:0] L_EMIT    = 5'd23;
    localparam logic [UPC_BITS-1:0] L_ONE     = 5'd24;
    localparam logic [UPC_BITS-1:0] L_ERR     = 5'd25;
    localparam logic [UPC_BITS-1:0] L_ZERO    = 5'd26;
    localparam logic [UPC_BITS-1:0] L_CONV    = 5'd27;

    // Microcode ROM: one control word per step
    function automatic t_uinst mfam_ucode(input logic [UPC_BITS-1:0] pc);
        t_uinst u;
        case (pc)
            5'd0:  u = '{OP_WAIT_IN,       C_NEXT,      L_IDLE};
            5'd1:  u = '{OP_NOP,           C_FUNC_BAD,  L_ZERO};
            5'd2:  u = '{OP_MUL_W1D1,      C_DEN_ERR,   L_ERR};
            5'd3:  u = '{OP_SET_T1,        C_FUNC_CONV, L_CONV};
            5'd4:  u = '{OP_MUL_W2D2,      C_NEXT,      L_IDLE};
            5'd5:  u = '{OP_SET_T2,        C_FUNC_MUL,  L_MUL};
            // add: t1*d2 + d1*t2
            5'd6:  u = '{OP_MUL_T1D2,      C_NEXT,      L_IDLE};
            5'd7:  u = '{OP_ACC_LOAD,      C_NEXT,      L_IDLE};
            5'd8:  u = '{OP_MUL_D1T2,      C_NEXT,      L_IDLE};
            5'd9:  u = '{OP_ACC_ADD,       C_ALWAYS,    L_DEN};
            // multiply: t1*t2
            5'd10: u = '{OP_MUL_T1T2,      C_NEXT,      L_IDLE};
            5'd11: u = '{OP_ACC_LOAD,      C_NEXT,      L_IDLE};
            // denominator and reduction
            5'd12: u = '{OP_MUL_D1D2,      C_NEXT,      L_IDLE};
            5'd13: u = '{OP_LOAD_DEN,      C_NUM_ZERO,  L_ONE};
            5'd14: u = '{OP_GCD_INIT,      C_NEXT,      L_IDLE};
            5'd15: u = '{OP_GCD_STEP,      C_GCD_RUN,   L_GCD};
            5'd16: u = '{OP_GCD_DONE,      C_NEXT,      L_IDLE};
            5'd17: u = '{OP_DIV_LOAD_NUM,  C_NEXT,      L_IDLE};
            5'd18: u = '{OP_DIV_STEP,      C_DIV_MORE,  L_DIV_NUM};
            5'd19: u = '{OP_DIV_STORE_NUM, C_NEXT,      L_IDLE};
            5'd20: u = '{OP_DIV_LOAD_DEN,  C_NEXT,      L_IDLE};
            5'd21: u = '{OP_DIV_STEP,      C_DIV_MORE,  L_DIV_DEN};
            5'd22: u = '{OP_DIV_STORE_DEN, C_NEXT,      L_IDLE};
            5'd23: u = '{OP_EMIT,          C_ALWAYS,    L_IDLE};
            // short exits
            5'd24: u = '{OP_SET_ONE,       C_ALWAYS,    L_EMIT};
            5'd25: u = '{OP_SET_ERR,       C_ALWAYS,    L_EMIT};
            5'd26: u = '{OP_SET_ZERO,      C_ALWAYS,    L_EMIT};
            5'd27: u = '{OP_CONV,          C_ALWAYS,    L_EMIT};
            default: u = '{OP_NOP,         C_ALWAYS,    L_IDLE};
        endcase
        return u;
    endfunction

endpackage

### hdl/mfam_useq.sv
// Microsequencer: step counter, microcode ROM lookup and conditional jumps.
// Depends on mfam_pkg.
module mfam_useq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_hold,
    input  mfam_pkg::t_dp_flags i_flags,
    output mfam_pkg::t_uinst   o_uinst
);
    import mfam_pkg::*;

    logic [UPC_BITS-1:0] r_pc;
    logic [UPC_BITS-1:0] n_pc;
    t_uinst              uinst;
    logic                jump;

    assign uinst = mfam_ucode(r_pc);

    // Jump condition select
    always_comb begin
        case (uinst.cond)
            C_NEXT:      jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_FUNC_BAD:  jump = i_flags.func_bad;
            C_DEN_ERR:   jump = i_flags.den_err;
            C_FUNC_CONV: jump = i_flags.func_conv;
            C_FUNC_MUL:  jump = i_flags.func_mul;
            C_NUM_ZERO:  jump = i_flags.num_zero;
            C_GCD_RUN:   jump = i_flags.gcd_run;
            C_DIV_MORE:  jump = i_flags.div_more;
            default:     jump = 1'b0;
        endcase
    end

    // Next step
    always_comb begin
        if (i_hold) begin
            n_pc = r_pc;
        end else if (jump) begin
            n_pc = uinst.target;
        end else begin
            n_pc = r_pc + UPC_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= L_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uinst = uinst;

endmodule

### hdl/mfam_dpath.sv
// Datapath: operand registers, shared multiplier, accumulator, binary GCD
// and bit-serial restoring divider, all steered by micro-ops.
// Depends on mfam_pkg.
module mfam_dpath (
    input  logic                i_clk,
    input  mfam_pkg::t_uinst    i_uinst,
    input  logic                i_take,
    input  mfam_pkg::t_in_item  i_in,
    output mfam_pkg::t_dp_flags o_flags,
    output mfam_pkg::t_out_item o_result
);
    import mfam_pkg::*;

    t_in_item                   r_in;
    logic signed [T_BITS-1:0]   r_t1;
    logic signed [T_BITS-1:0]   r_t2;
    logic signed [NUM_BITS-1:0] r_prod;
    logic signed [NUM_BITS-1:0] r_num;
    logic [DEN_BITS-1:0]        r_den;
    logic                       r_err;
    logic                       r_neg;
    logic [MAG_BITS-1:0]        r_mag;
    logic [MAG_BITS-1:0]        r_ga;
    logic [MAG_BITS-1:0]        r_gb;
    logic [K_BITS-1:0]          r_k;
    logic [DEN_BITS-1:0]        r_g;
    logic [MAG_BITS-1:0]        r_quo;
    logic [DEN_BITS-1:0]        r_rem;
    logic [CNT_BITS-1:0]        r_cnt;

    logic signed [MUL_BITS-1:0]   mul_a;
    logic signed [MUL_BITS-1:0]   mul_b;
    logic signed [2*MUL_BITS-1:0] mul_p;
    logic [NUM_BITS-1:0]          num_neg;
    logic [MAG_BITS-1:0]          num_abs;
    logic [MAG_BITS-1:0]          diff_ab;
    logic [MAG_BITS-1:0]          diff_ba;
    logic [MAG_BITS-1:0]          g_full;
    logic [DEN_BITS:0]            rem_sh;
    logic [DEN_BITS:0]            rem_sub;
    logic                         fits;
    logic [NUM_BITS-1:0]          quo_ext;

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_uinst.op)
            OP_MUL_W1D1: begin
                mul_a = MUL_BITS'($signed(r_in.first_whole));
                mul_b = MUL_BITS'({1'b0, r_in.first_denominator});
            end
            OP_MUL_W2D2: begin
                mul_a = MUL_BITS'($signed(r_in.second_whole));
                mul_b = MUL_BITS'({1'b0, r_in.second_denominator});
            end
            OP_MUL_T1D2: begin
                mul_a = MUL_BITS'(r_t1);
                mul_b = MUL_BITS'({1'b0, r_in.second_denominator});
            end
            OP_MUL_D1T2: begin
                mul_a = MUL_BITS'({1'b0, r_in.first_denominator});
                mul_b = MUL_BITS'(r_t2);
            end
            OP_MUL_T1T2: begin
                mul_a = MUL_BITS'(r_t1);
                mul_b = MUL_BITS'(r_t2);
            end
            OP_MUL_D1D2: begin
                mul_a = MUL_BITS'({1'b0, r_in.first_denominator});
                mul_b = MUL_BITS'({1'b0, r_in.second_denominator});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Magnitude of the unreduced numerator
    assign num_neg = -r_num;
    assign num_abs = r_num[NUM_BITS-1] ? num_neg[MAG_BITS-1:0] : r_num[MAG_BITS-1:0];

    // GCD helpers
    assign diff_ab = r_ga - r_gb;
    assign diff_ba = r_gb - r_ga;
    assign g_full  = (r_ga | r_gb) << r_k;

    // Divider step: shift in next dividend bit, subtract when it fits
    assign rem_sh  = {r_rem, r_quo[MAG_BITS-1]};
    assign fits    = (rem_sh >= {1'b0, r_g});
    assign rem_sub = rem_sh - {1'b0, r_g};
    assign quo_ext = {1'b0, r_quo};

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_in  <= i_in;
            r_err <= 1'b0;
        end
        case (i_uinst.op)
            OP_MUL_W1D1, OP_MUL_W2D2, OP_MUL_T1D2,
            OP_MUL_D1T2, OP_MUL_T1T2, OP_MUL_D1D2: begin
                r_prod <= mul_p[NUM_BITS-1:0];
            end
            OP_SET_T1: r_t1 <= r_prod[T_BITS-1:0] + T_BITS'(r_in.first_numerator);
            OP_SET_T2: r_t2 <= r_prod[T_BITS-1:0] + T_BITS'(r_in.second_numerator);
            OP_ACC_LOAD: r_num <= r_prod;
            OP_ACC_ADD:  r_num <= r_num + r_prod;
            OP_LOAD_DEN: r_den <= r_prod[DEN_BITS-1:0];
            OP_GCD_INIT: begin
                r_neg <= r_num[NUM_BITS-1];
                r_mag <= num_abs;
                r_ga  <= num_abs;
                r_gb  <= MAG_BITS'(r_den);
                r_k   <= '0;
            end
            // Binary GCD: strip common twos, then odd minus odd halves
            OP_GCD_STEP: begin
                if (r_ga != '0 && r_gb != '0) begin
                    if (!r_ga[0] && !r_gb[0]) begin
                        r_ga <= r_ga >> 1;
                        r_gb <= r_gb >> 1;
                        r_k  <= r_k + K_BITS'(1);
                    end else if (!r_ga[0]) begin
                        r_ga <= r_ga >> 1;
                    end else if (!r_gb[0]) begin
                        r_gb <= r_gb >> 1;
                    end else if (r_ga >= r_gb) begin
                        r_ga <= diff_ab >> 1;
                    end else begin
                        r_gb <= diff_ba >> 1;
                    end
                end
            end
            OP_GCD_DONE: r_g <= g_full[DEN_BITS-1:0];
            OP_DIV_LOAD_NUM: begin
                r_quo <= r_mag;
                r_rem <= '0;
                r_cnt <= CNT_BITS'(MAG_BITS);
            end
            OP_DIV_LOAD_DEN: begin
                r_quo <= MAG_BITS'(r_den);
                r_rem <= '0;
                r_cnt <= CNT_BITS'(MAG_BITS);
            end
            OP_DIV_STEP: begin
                r_rem <= fits ? rem_sub[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
                r_quo <= {r_quo[MAG_BITS-2:0], fits};
                r_cnt <= r_cnt - CNT_BITS'(1);
            end
            OP_DIV_STORE_NUM: r_num <= r_neg ? -quo_ext : quo_ext;
            OP_DIV_STORE_DEN: r_den <= r_quo[DEN_BITS-1:0];
            OP_SET_ONE: r_den <= DEN_BITS'(1);
            OP_SET_ERR: begin
                r_num <= '0;
                r_den <= '0;
                r_err <= 1'b1;
            end
            OP_SET_ZERO: begin
                r_num <= '0;
                r_den <= '0;
                r_err <= 1'b0;
            end
            OP_CONV: begin
                r_num <= NUM_BITS'(r_t1);
                r_den <= DEN_BITS'(r_in.first_denominator);
                r_err <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Status for the sequencer
    always_comb begin
        o_flags.func_bad  = (r_in.func != FN_CONVERT) && (r_in.func != FN_ADD)
                            && (r_in.func != FN_MULTIPLY);
        o_flags.den_err   = (r_in.first_denominator == '0)
                            || ((r_in.func != FN_CONVERT) && (r_in.second_denominator == '0));
        o_flags.func_conv = (r_in.func == FN_CONVERT);
        o_flags.func_mul  = (r_in.func == FN_MULTIPLY);
        o_flags.num_zero  = (r_num == '0);
        o_flags.gcd_run   = (r_ga != '0) && (r_gb != '0);
        o_flags.div_more  = (r_cnt != CNT_BITS'(1));
    end

    assign o_result.result_numerator       = r_num;
    assign o_result.result_denominator     = r_den;
    assign o_result.zero_denominator_error = r_err;

endmodule

### hdl/mixed_fraction_add_multiply.sv
// Top level of the mixed-number fraction unit: microsequencer, datapath and
// output register. Depends on mfam_pkg, mfam_useq and mfam_dpath.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+-----------------------
//   in      | input     | i_in_valid / o_in_stall     | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall   | o_out_data (t_out_item)
//
// One item at a time. Convert, the error exits and a zero sum or product take short
// exits; otherwise add and multiply run the binary GCD loop and two 44-step
// passes of the bit-serial divider, so their run time depends on the operands.
// A transfer is taken only while the sequencer sits in its wait step; the
// output register lets the next item start while a result is still stalled.
// Reset clears the step counter and output valid and holds the input stalled.
module mixed_fraction_add_multiply (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mfam_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mfam_pkg::t_out_item o_out_data
);
    import mfam_pkg::*;

    t_uinst    uinst;
    t_dp_flags flags;
    t_out_item result;
    logic      take;
    logic      hold;
    logic      load_out;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out_data;

    // Input transfer only in the wait step, never during reset
    assign o_in_stall = !i_rst_n || (uinst.op != OP_WAIT_IN);
    assign take       = !o_in_stall && i_in_valid;

    // Result goes out when the output register is free or draining
    assign load_out = (uinst.op == OP_EMIT) && (!r_out_valid || !i_out_stall);
    assign hold     = ((uinst.op == OP_WAIT_IN) && !i_in_valid)
                      || ((uinst.op == OP_EMIT) && r_out_valid && i_out_stall);

    mfam_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (hold),
        .i_flags (flags),
        .o_uinst (uinst)
    );

    mfam_dpath u_dpath (
        .i_clk    (i_clk),
        .i_uinst  (uinst),
        .i_take   (take),
        .i_in     (i_in_data),
        .o_flags  (flags),
        .o_result (result)
    );

    // Output register
    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### hdl/mfam_checker.sv
// Port-level checks for the mixed-number fraction unit, bound to the top.
// Depends on mfam_pkg and mixed_fraction_add_multiply.
module mfam_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input mfam_pkg::t_out_item o_out_data
);
    import mfam_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Error results carry a zero fraction
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_denominator_error
        |-> o_out_data.result_numerator == '0 && o_out_data.result_denominator == '0)
        else $error("error result with nonzero fraction");

    // A zero denominator only comes with a zero numerator
    a_den_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_denominator == '0
        |-> o_out_data.result_numerator == '0)
        else $error("zero denominator with nonzero numerator");

    // One item at a time: input stalls right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second input transfer while busy");

endmodule

bind mixed_fraction_add_multiply mfam_checker u_mfam_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
